@@ hw/rtl/mbec_pkg.sv @@
// shared types, constants and helpers for the escape-time counter
// no dependencies; imported by every module of the block
package mbec_pkg;

  localparam int unsigned FRAC_BITS    = 28;
  localparam int unsigned IMAGE_WIDTH  = 800;
  localparam int unsigned IMAGE_HEIGHT = 600;

  localparam logic signed [31:0] XMIN_RESET = -32'sd536870912;
  localparam logic signed [31:0] YMIN_RESET = -32'sd402653184;
  localparam logic [30:0] XSTEP_RESET = 31'((64'd4 << FRAC_BITS) / IMAGE_WIDTH);
  localparam logic [30:0] YSTEP_RESET = 31'((64'd3 << FRAC_BITS) / IMAGE_HEIGHT);
  localparam logic [7:0]  MAXSTEPS_RESET = 8'd30;

  // |z|^2 limit of 4 in unsigned Q9.56
  localparam logic [64:0] ESCAPE_LIMIT = 65'd4 << (2 * FRAC_BITS);

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_X_MIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_MIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_X_STEP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_Y_STEP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STEPS = 3'd4;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] y_min;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [7:0]         max_steps;
  } cfg_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mbec_mul.sv @@
// shared signed 32x32 multiplier with a registered 64-bit product
// depends on mbec_pkg
module mbec_mul
  import mbec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] op_a_i,
  input  logic signed [31:0] op_b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] a_ext;
  logic signed [63:0] b_ext;
  logic signed [63:0] prod_d;
  logic signed [63:0] prod_q;

  assign a_ext  = {{32{op_a_i[31]}}, op_a_i};
  assign b_ext  = {{32{op_b_i[31]}}, op_b_i};
  assign prod_d = a_ext * b_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ hw/rtl/mbec_cfg.sv @@
// view and limit registers written through the plain config port
// depends on mbec_pkg
module mbec_cfg
  import mbec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_d;
  cfg_t cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_MIN:     cfg_d.x_min     = cfg_data_i;
        CFG_Y_MIN:     cfg_d.y_min     = cfg_data_i;
        CFG_X_STEP:    cfg_d.x_step    = cfg_data_i[30:0];
        CFG_Y_STEP:    cfg_d.y_step    = cfg_data_i[30:0];
        CFG_MAX_STEPS: cfg_d.max_steps = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;  // unknown index is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min     <= XMIN_RESET;
      cfg_q.y_min     <= YMIN_RESET;
      cfg_q.x_step    <= XSTEP_RESET;
      cfg_q.y_step    <= YSTEP_RESET;
      cfg_q.max_steps <= MAXSTEPS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/mandelbrot_escape_count.sv @@
// Mandelbrot escape-time counter: takes a pixel beat, returns its iteration count.
// Channels: s_axis (pixel in), m_axis (count out), plain config write port.
// Each pixel is mapped to c = (x_min + px*x_step, y_min + py*y_step) in signed
// Q4.28, saturated, then z = z^2 + c runs from z = 0 until |z|^2 > 4 or the
// count reaches max_steps. inside_res is set when the count equals max_steps.
// One signed 32x32 multiplier with a registered product is shared by all work:
// coordinate mapping (MX, MY, CI), then per iteration a*a, b*b, a*b and the update
// (AA, BB, AB, UPD), a last escape check (AA, BB, AB) and a hand-off in DONE.
// s_axis_tready rises again in the same cycle that the result enters the output
// register, so a new pixel is taken only after the last one has been handed off.
// The result sits in an output register: a new pixel is accepted while it
// waits. If m_axis stalls with a result still held, the next finished pixel
// waits in the done state and no new pixel is taken until the slot frees.
// Reset restores the default view (-2.0, -1.5, 4.0/800, 3.0/600, limit 30) and
// empties the output register. User must write config only while idle; not enforced.
// depends on mbec_pkg, mbec_cfg, mbec_mul
module mandelbrot_escape_count
  import mbec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata    // step_count[7:0], inside_res[8], zero pad
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_CI   = 4'd3;
  localparam logic [3:0] S_AA   = 4'd4;
  localparam logic [3:0] S_BB   = 4'd5;
  localparam logic [3:0] S_AB   = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  cfg_t cfg;

  logic [3:0] state_d, state_q;
  logic [9:0] px_d, px_q, py_d, py_q;
  logic signed [31:0] cr_d, cr_q, ci_d, ci_q;
  logic signed [31:0] a_d, a_q, b_d, b_q;
  logic signed [63:0] aa_d, aa_q, diff_d, diff_q;
  logic [7:0] steps_d, steps_q;
  logic       out_valid_d, out_valid_q;
  logic [7:0] out_cnt_d, out_cnt_q;
  logic       out_inside_d, out_inside_q;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [43:0] map_x_sum, map_y_sum, re_sum, im_sum;
  logic [64:0]        mag;
  logic               in_beat, out_free;

  mbec_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mbec_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // multiplier operand select
  always_comb begin
    case (state_q)
      S_MX: begin
        op_a = {22'd0, px_q};
        op_b = {1'b0, cfg.x_step};
      end
      S_MY: begin
        op_a = {22'd0, py_q};
        op_b = {1'b0, cfg.y_step};
      end
      S_AA: begin
        op_a = a_q;
        op_b = a_q;
      end
      S_BB: begin
        op_a = b_q;
        op_b = b_q;
      end
      default: begin
        op_a = a_q;
        op_b = b_q;
      end
    endcase
  end

  // mapping product is below 2^41
  assign map_x_sum = {{12{cfg.x_min[31]}}, cfg.x_min} + {3'd0, prod[40:0]};
  assign map_y_sum = {{12{cfg.y_min[31]}}, cfg.y_min} + {3'd0, prod[40:0]};
  // floor shifts by taking the upper bits of the signed words
  assign re_sum = {{8{diff_q[63]}}, diff_q[63:28]} + {{12{cr_q[31]}}, cr_q};
  assign im_sum = {{7{prod[63]}}, prod[63:27]} + {{12{ci_q[31]}}, ci_q};
  // squares are never negative
  assign mag    = {1'b0, aa_q} + {1'b0, prod};

  always_comb begin
    state_d      = state_q;
    px_d         = px_q;
    py_d         = py_q;
    cr_d         = cr_q;
    ci_d         = ci_q;
    a_d          = a_q;
    b_d          = b_q;
    aa_d         = aa_q;
    diff_d       = diff_q;
    steps_d      = steps_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_cnt_d    = out_cnt_q;
    out_inside_d = out_inside_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          px_d    = s_axis_tdata[9:0];
          py_d    = s_axis_tdata[19:10];
          state_d = S_MX;
        end
      end
      S_MX: state_d = S_MY;
      S_MY: begin
        cr_d    = sat32(map_x_sum);
        state_d = S_CI;
      end
      S_CI: begin
        ci_d    = sat32(map_y_sum);
        a_d     = '0;
        b_d     = '0;
        steps_d = '0;
        state_d = S_AA;
      end
      S_AA: state_d = S_BB;
      S_BB: begin
        aa_d    = prod;
        state_d = S_AB;
      end
      S_AB: begin
        diff_d = aa_q - prod;
        // z from the previous update escapes, or the limit is reached
        if ((mag > ESCAPE_LIMIT) || (steps_q == cfg.max_steps)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        a_d     = sat32(re_sum);
        b_d     = sat32(im_sum);
        steps_d = steps_q + 8'd1;
        state_d = S_AA;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_cnt_d    = steps_q;
          out_inside_d = (steps_q == cfg.max_steps);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q         <= px_d;
    py_q         <= py_d;
    cr_q         <= cr_d;
    ci_q         <= ci_d;
    a_q          <= a_d;
    b_q          <= b_d;
    aa_q         <= aa_d;
    diff_q       <= diff_d;
    steps_q      <= steps_d;
    out_cnt_q    <= out_cnt_d;
    out_inside_q <= out_inside_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_inside_q, out_cnt_q};

  a_accept_starts_map: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_MX)
  ) else $error("accepted pixel did not start coordinate mapping");

  a_result_from_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE)
  ) else $error("result appeared without a finished pixel");

  a_done_hands_off: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE)
  ) else $error("finished pixel was not moved to the output register");

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for mandelbrot_escape_count: pixel beats in, escape counts out
// carries its own fixed-point escape-time predictor and compares every result beat
// depends on mbec_pkg and the mandelbrot_escape_count rtl
module tb_top;
  import mbec_pkg::*;

  localparam longint Q428_MAX = 64'sd2147483647;
  localparam longint Q428_MIN = -64'sd2147483648;
  localparam logic [63:0] MAG_LIMIT = 64'd4 << (2 * FRAC_BITS);
  localparam int unsigned N_RANDOM_VIEWS = 8;
  localparam int unsigned PIXELS_PER_VIEW = 50;

  typedef struct {
    logic [9:0] px;
    logic [9:0] py;
  } pixel_t;

  typedef struct {
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] count;
    logic       in_set;
  } escape_result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;   // pixel_x[9:0], pixel_y[19:10], zero pad
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;        // step_count[7:0], inside_res[8], zero pad

  mandelbrot_escape_count dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // view registers as the predictor sees them
  longint      view_x_min = longint'(XMIN_RESET);
  longint      view_y_min = longint'(YMIN_RESET);
  longint      view_x_step = longint'({1'b0, XSTEP_RESET});
  longint      view_y_step = longint'({1'b0, YSTEP_RESET});
  int unsigned view_limit = int'(MAXSTEPS_RESET);

  pixel_t         pixel_q[$];
  escape_result_t escape_expect_q[$];
  pixel_t         next_pixel;
  escape_result_t want;

  int n_errors = 0;
  int n_checked = 0;
  int n_inside = 0;
  int n_open = 0;
  int n_views = 0;
  int max_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int ready_run = 0;
  rx_mode_e ready_mode = RX_OPEN;

  function automatic longint clamp_q428(input longint v);
    if (v > Q428_MAX) return Q428_MAX;
    if (v < Q428_MIN) return Q428_MIN;
    return v;
  endfunction

  function automatic escape_result_t predict_escape(input logic [9:0] px, input logic [9:0] py);
    longint         cr, ci, a, b, na, nb;
    logic [63:0]    mag;
    int unsigned    n;
    escape_result_t r;
    cr = clamp_q428(view_x_min + longint'({54'd0, px}) * view_x_step);
    ci = clamp_q428(view_y_min + longint'({54'd0, py}) * view_y_step);
    a = 0;
    b = 0;
    n = 0;
    while (n < view_limit) begin
      n++;
      // arithmetic shift of the exact product is the floor division
      na = clamp_q428(((a * a - b * b) >>> FRAC_BITS) + cr);
      nb = clamp_q428(((a * b) >>> (FRAC_BITS - 1)) + ci);
      a = na;
      b = nb;
      mag = a * a + b * b;
      if (mag > MAG_LIMIT) break;
    end
    r.px = px;
    r.py = py;
    r.count = n[7:0];
    r.in_set = (n == view_limit);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_X_MIN:     view_x_min = longint'(signed'(data));
      CFG_Y_MIN:     view_y_min = longint'(signed'(data));
      CFG_X_STEP:    view_x_step = longint'({1'b0, data[30:0]});
      CFG_Y_STEP:    view_y_step = longint'({1'b0, data[30:0]});
      CFG_MAX_STEPS: view_limit = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_view(input logic [31:0] xmin, input logic [31:0] ymin,
                          input logic [31:0] xstep, input logic [31:0] ystep,
                          input logic [31:0] limit);
    write_reg(CFG_X_MIN, xmin);
    write_reg(CFG_Y_MIN, ymin);
    write_reg(CFG_X_STEP, xstep);
    write_reg(CFG_Y_STEP, ystep);
    write_reg(CFG_MAX_STEPS, limit);
  endtask

  task automatic queue_pixel(input logic [9:0] px, input logic [9:0] py);
    pixel_q.push_back('{px, py});
    n_open++;
  endtask

  task automatic wait_drained();
    while (n_open != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // pixel driver: bursts of beats separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        escape_expect_q.push_back(predict_escape(s_axis_tdata[9:0], s_axis_tdata[19:10]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          next_pixel = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'd0, next_pixel.py, next_pixel.px};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure, switching between open, coin-flip and mostly stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ready_run == 0) begin
        ready_mode = rx_mode_e'($urandom_range(0, 2));
        ready_run = $urandom_range(16, 160);
      end else begin
        ready_run--;
      end
      case (ready_mode)
        RX_OPEN: m_axis_tready <= 1'b1;
        RX_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
        default: m_axis_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (escape_expect_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no pixel outstanding", m_axis_tdata));
      end else begin
        want = escape_expect_q.pop_front();
        if (m_axis_tdata[7:0] !== want.count) begin
          report_mismatch($sformatf("pixel (%0d,%0d) step_count %0d, expected %0d",
                                    want.px, want.py, m_axis_tdata[7:0], want.count));
        end
        if (m_axis_tdata[8] !== want.in_set) begin
          report_mismatch($sformatf("pixel (%0d,%0d) inside_res %b, expected %b",
                                    want.px, want.py, m_axis_tdata[8], want.in_set));
        end
        n_checked++;
        n_open--;
        if (want.in_set) n_inside++;
        if (int'(want.count) > max_count) max_count = want.count;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("mandelbrot_escape_count regression: fail");
    $finish;
  end

  initial begin
    logic [9:0]  px, py;
    logic [31:0] xmin, ymin, xstep, ystep, limit;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default view: corners, center, pixels beyond the image
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd799, 10'd599);
    queue_pixel(10'd400, 10'd300);
    queue_pixel(10'd1023, 10'd1023);
    queue_pixel(10'd0, 10'd599);
    queue_pixel(10'd799, 10'd0);
    queue_pixel(10'd550, 10'd300);
    wait_drained();

    // longest iteration limit on real-axis points, two in the set and one outside it
    write_reg(CFG_MAX_STEPS, 32'd255);
    queue_pixel(10'd400, 10'd300);
    queue_pixel(10'd300, 10'd300);
    queue_pixel(10'd520, 10'd300);
    wait_drained();

    // zero limit: no iteration at all
    write_reg(CFG_MAX_STEPS, 32'd0);
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd400, 10'd300);
    wait_drained();

    // limit of one: a far point escapes right on the last step
    write_reg(CFG_MAX_STEPS, 32'd1);
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd400, 10'd300);
    wait_drained();

    // extreme view: c saturates to the Q4.28 range
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd255);
    queue_pixel(10'd1023, 10'd1023);
    queue_pixel(10'd0, 10'd0);
    queue_pixel(10'd1023, 10'd0);
    wait_drained();

    // writes to unused indexes must leave the view alone; zero step pins every pixel
    for (int k = 1; k <= 3; k++) write_reg(CfgIdxW'(CFG_MAX_STEPS + k), $urandom());
    set_view(32'hF400_0000, 32'h0000_0000, 32'd0, 32'd0, 32'd255);
    queue_pixel(10'd5, 10'd5);
    queue_pixel(10'd1023, 10'd1023);
    wait_drained();

    for (int v = 0; v < N_RANDOM_VIEWS; v++) begin
      xmin = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'd805306368) - 32'd671088640
                                         : $urandom();
      ymin = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'd536870912) - 32'd402653184
                                         : $urandom();
      xstep = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 32'd2097152) : $urandom();
      ystep = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 32'd2097152) : $urandom();
      if (v == 3) limit = $urandom_range(200, 255);
      else if ($urandom_range(0, 3) != 0) limit = $urandom_range(1, 48);
      else limit = $urandom_range(0, 255);
      if ($urandom_range(0, 2) == 0) write_reg(CfgIdxW'(CFG_MAX_STEPS + $urandom_range(1, 3)),
                                               $urandom());
      set_view(xmin, ymin, xstep, ystep, {24'($urandom_range(0, 32'hFF_FFFF)), limit[7:0]});
      n_views++;
      for (int i = 0; i < PIXELS_PER_VIEW; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          px = $urandom_range(0, 1023);
          py = $urandom_range(0, 1023);
        end else begin
          px = $urandom_range(0, IMAGE_WIDTH - 1);
          py = $urandom_range(0, IMAGE_HEIGHT - 1);
        end
        queue_pixel(px, py);
        // hold the sender halfway until the pipe has fully drained
        if (i == PIXELS_PER_VIEW / 2 - 1) wait_drained();
      end
      wait_drained();
    end

    repeat (60) @(posedge clk_i);
    $display("checked %0d pixels over the directed views and %0d random views", n_checked, n_views);
    $display("%0d pixels hit the iteration limit, highest count seen %0d", n_inside, max_count);
    if (n_errors == 0 && escape_expect_q.size() == 0) begin
      $display("mandelbrot_escape_count regression: pass");
    end else begin
      $display("mandelbrot_escape_count regression: fail");
    end
    $finish;
  end

endmodule
